@@ design/pwlc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlc_pkg
// Constants, stage types and per-stage step functions of the piecewise
// linear colormap pipeline.
// ----------------------------------------------------------------------------
package pwlc_pkg;

  // Ramp geometry
  localparam int NUM_STOPS = 6;
  localparam int POS_BITS  = 10;

  // Field and register widths
  localparam int VAL_W       = 32;
  localparam int SPAN_W      = 32;
  localparam int CH_W        = 8;
  localparam int RGB_W       = 3 * CH_W;
  localparam int POS_REG_W   = 60;
  localparam int COLOR_REG_W = 48;
  localparam int DIVN_W      = SPAN_W + POS_BITS;
  localparam int BLEND_W     = CH_W + POS_BITS;

  // Configuration port
  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W  = 3;
  localparam int REG_LSB    = 3;

  localparam logic [REG_IDX_W-1:0] REG_RANGE_MIN = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RANGE_MAX = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STOP_POS  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COLORS_01 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COLORS_23 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COLORS_45 = 3'd5;

  // Register reset values
  localparam logic [VAL_W-1:0]       RST_RANGE_MIN = 32'd0;
  localparam logic [VAL_W-1:0]       RST_RANGE_MAX = 32'd65536;
  localparam logic [POS_REG_W-1:0]   RST_STOP_POS  = 60'd1152865154099145728;
  localparam logic [COLOR_REG_W-1:0] RST_COLORS_01 = 48'd281470698520575;
  localparam logic [COLOR_REG_W-1:0] RST_COLORS_23 = 48'd182797462994944;
  localparam logic [COLOR_REG_W-1:0] RST_COLORS_45 = 48'd7536780;

  // Range status codes
  localparam logic [1:0] STATUS_IN_RANGE = 2'd0;
  localparam logic [1:0] STATUS_BELOW    = 2'd1;
  localparam logic [1:0] STATUS_ABOVE    = 2'd2;

  // Fixed colors for values outside the range
  localparam logic [RGB_W-1:0] COLOR_BELOW = 24'h66FF66;
  localparam logic [RGB_W-1:0] COLOR_ABOVE = 24'h009900;

  // Pipeline: range check, scale, POS_BITS divide steps, stop search,
  // products, sums, CH_W divide steps, output register
  localparam int PIPE_DEPTH = POS_BITS + CH_W + 6;

  // Range check stage
  typedef struct packed {
    logic [1:0]        status;
    logic              degen;
    logic [SPAN_W-1:0] num;
    logic [SPAN_W-1:0] den;
  } rng_t;

  // Position divide stage
  typedef struct packed {
    logic [1:0]          status;
    logic                degen;
    logic [SPAN_W-1:0]   den;
    logic [DIVN_W-1:0]   rem;
    logic [POS_BITS-1:0] quo;
  } tdiv_t;

  // Stop search stage
  typedef struct packed {
    logic [1:0]          status;
    logic                blend;
    logic [RGB_W-1:0]    base;
    logic [RGB_W-1:0]    ca;
    logic [RGB_W-1:0]    cb;
    logic [POS_BITS-1:0] n;
    logic [POS_BITS-1:0] d;
  } srch_t;

  // Blend product stage
  typedef struct packed {
    logic [1:0]             status;
    logic                   blend;
    logic [RGB_W-1:0]       base;
    logic [POS_BITS-1:0]    d;
    logic [2:0][BLEND_W-1:0] pa;
    logic [2:0][BLEND_W-1:0] pb;
  } prod_t;

  // Blend divide stage
  typedef struct packed {
    logic [1:0]              status;
    logic                    blend;
    logic [RGB_W-1:0]        base;
    logic [POS_BITS-1:0]     d;
    logic [2:0][BLEND_W-1:0] rem;
    logic [2:0][CH_W-1:0]    quo;
  } bdiv_t;

  // Output register
  typedef struct packed {
    logic [1:0]       status;
    logic [RGB_W-1:0] rgb;
  } out_t;

  // Position of stop k
  function automatic logic [POS_BITS-1:0] stop_pos(logic [POS_REG_W-1:0] pos, int k);
    return pos[POS_BITS*k +: POS_BITS];
  endfunction

  // RGB888 of stop k
  function automatic logic [RGB_W-1:0] stop_rgb(logic [COLOR_REG_W-1:0] c01,
                                                logic [COLOR_REG_W-1:0] c23,
                                                logic [COLOR_REG_W-1:0] c45,
                                                int k);
    logic [COLOR_REG_W-1:0] pair;
    unique case (k)
      0, 1:    pair = c01;
      2, 3:    pair = c23;
      default: pair = c45;
    endcase
    return k[0] ? pair[COLOR_REG_W-1:RGB_W] : pair[RGB_W-1:0];
  endfunction

  // One restoring step of the position divide, quotient bit qb
  function automatic tdiv_t tdiv_step(tdiv_t s, int qb);
    tdiv_t             r;
    logic [DIVN_W-1:0] dsh;
    r   = s;
    dsh = {{POS_BITS{1'b0}}, s.den} << qb;
    if (s.rem >= dsh) begin
      r.rem     = s.rem - dsh;
      r.quo[qb] = 1'b1;
    end
    return r;
  endfunction

  // One restoring step of the three blend divides, quotient bit qb
  function automatic bdiv_t bdiv_step(bdiv_t s, int qb);
    bdiv_t              r;
    logic [BLEND_W-1:0] dsh;
    r   = s;
    dsh = {{CH_W{1'b0}}, s.d} << qb;
    for (int c = 0; c < 3; c++) begin
      if (s.rem[c] >= dsh) begin
        r.rem[c]     = s.rem[c] - dsh;
        r.quo[c][qb] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

@@ design/pwlc_channels.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlc channels
// Valid/ready channels for the sample input and the color output.
// ----------------------------------------------------------------------------

// Sample channel: one Q16.16 value per item
interface pwlc_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

// Color channel: RGB888 and range status per item
interface pwlc_color_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [1:0] range_status;

  modport source (output valid, output red, output green, output blue,
                  output range_status, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input range_status, output ready);
endinterface

@@ design/piecewise_linear_colormap_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_colormap_top
// Maps a signed Q16.16 sample to an RGB888 color through a ramp of stops.
//
// The block takes one sample per clock while the output item is not stalled
// and returns one color item for each, in order, through POS_BITS + 14 = 24
// register stages: the position divide, one quotient bit per stage, and the
// per-channel blend divide, one bit per stage for eight bits, plus the range
// check, scale, stop search, product, sum and output stages. All stages share
// one enable: while the output item waits, the whole pipe holds, and empty
// stages do not fill. Range and ramp registers sit on a 64-bit APB-style
// port at byte address 8*index and are meant to change only while the pipe
// is empty.
// ----------------------------------------------------------------------------
module piecewise_linear_colormap_top
  import pwlc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pwlc_sample_if.sink           sample_i,
  pwlc_color_if.source          color_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [VAL_W-1:0]  range_min_q;
  logic signed [VAL_W-1:0]  range_max_q;
  logic [POS_REG_W-1:0]     stop_pos_q;
  logic [COLOR_REG_W-1:0]   colors_01_q;
  logic [COLOR_REG_W-1:0]   colors_23_q;
  logic [COLOR_REG_W-1:0]   colors_45_q;
  logic [REG_IDX_W-1:0]     reg_idx;
  logic                     cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[REG_LSB +: REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Write on the access cycle; drop writes beyond the register list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_min_q <= RST_RANGE_MIN;
      range_max_q <= RST_RANGE_MAX;
      stop_pos_q  <= RST_STOP_POS;
      colors_01_q <= RST_COLORS_01;
      colors_23_q <= RST_COLORS_23;
      colors_45_q <= RST_COLORS_45;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_RANGE_MIN: range_min_q <= pwdata[VAL_W-1:0];
        REG_RANGE_MAX: range_max_q <= pwdata[VAL_W-1:0];
        REG_STOP_POS:  stop_pos_q  <= pwdata[POS_REG_W-1:0];
        REG_COLORS_01: colors_01_q <= pwdata[COLOR_REG_W-1:0];
        REG_COLORS_23: colors_23_q <= pwdata[COLOR_REG_W-1:0];
        REG_COLORS_45: colors_45_q <= pwdata[COLOR_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_RANGE_MIN: prdata = {{(APB_DATA_W-VAL_W){1'b0}}, range_min_q};
      REG_RANGE_MAX: prdata = {{(APB_DATA_W-VAL_W){1'b0}}, range_max_q};
      REG_STOP_POS:  prdata = {{(APB_DATA_W-POS_REG_W){1'b0}}, stop_pos_q};
      REG_COLORS_01: prdata = {{(APB_DATA_W-COLOR_REG_W){1'b0}}, colors_01_q};
      REG_COLORS_23: prdata = {{(APB_DATA_W-COLOR_REG_W){1'b0}}, colors_23_q};
      REG_COLORS_45: prdata = {{(APB_DATA_W-COLOR_REG_W){1'b0}}, colors_45_q};
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic [PIPE_DEPTH-1:0] vld_q;
  logic                  en;

  assign en             = !vld_q[PIPE_DEPTH-1] || color_o.ready;
  assign sample_i.ready = en;

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], sample_i.valid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage combinational logic
  // --------------------------------------------------------------------------
  rng_t  rng_q,  rng_d;
  tdiv_t tdiv_q [POS_BITS+1];
  tdiv_t tdiv_d;
  srch_t srch_q, srch_d;
  prod_t prod_q, prod_d;
  bdiv_t bdiv_q [CH_W+1];
  bdiv_t bdiv_d;
  out_t  out_q,  out_d;

  // Range check and differences
  always_comb begin
    logic [VAL_W:0] num_w;
    logic [VAL_W:0] den_w;
    num_w = {sample_i.sample_value[VAL_W-1], sample_i.sample_value}
          - {range_min_q[VAL_W-1], range_min_q};
    den_w = {range_max_q[VAL_W-1], range_max_q} - {range_min_q[VAL_W-1], range_min_q};
    if (sample_i.sample_value < range_min_q) begin
      rng_d.status = STATUS_BELOW;
    end else if (sample_i.sample_value > range_max_q) begin
      rng_d.status = STATUS_ABOVE;
    end else begin
      rng_d.status = STATUS_IN_RANGE;
    end
    rng_d.degen = (range_max_q == range_min_q);
    rng_d.num   = num_w[SPAN_W-1:0];
    rng_d.den   = den_w[SPAN_W-1:0];
  end

  // Scale offset by 2^POS_BITS - 1 with a shift and subtract
  always_comb begin
    tdiv_d.status = rng_q.status;
    tdiv_d.degen  = rng_q.degen;
    tdiv_d.den    = rng_q.den;
    tdiv_d.rem    = {rng_q.num, {POS_BITS{1'b0}}} - {{POS_BITS{1'b0}}, rng_q.num};
    tdiv_d.quo    = '0;
  end

  // Find the first stop at or above t and pick the colors to blend
  always_comb begin
    logic [POS_BITS-1:0] t;
    logic [POS_BITS-1:0] p_lo;
    t            = tdiv_q[POS_BITS].quo;
    srch_d.status = tdiv_q[POS_BITS].status;
    srch_d.blend  = 1'b0;
    srch_d.base   = stop_rgb(colors_01_q, colors_23_q, colors_45_q, NUM_STOPS-1);
    srch_d.ca     = '0;
    srch_d.cb     = '0;
    srch_d.n      = '0;
    srch_d.d      = '0;
    p_lo          = '0;
    for (int k = NUM_STOPS-1; k >= 1; k--) begin
      if (stop_pos(stop_pos_q, k) >= t) begin
        p_lo         = stop_pos(stop_pos_q, k-1);
        srch_d.blend = 1'b1;
        srch_d.ca    = stop_rgb(colors_01_q, colors_23_q, colors_45_q, k-1);
        srch_d.cb    = stop_rgb(colors_01_q, colors_23_q, colors_45_q, k);
        srch_d.d     = stop_pos(stop_pos_q, k) - p_lo;
        srch_d.n     = t - p_lo;
      end
    end
    // At or before the first stop, or a degenerate range: first color
    if (stop_pos(stop_pos_q, 0) >= t || tdiv_q[POS_BITS].degen) begin
      srch_d.blend = 1'b0;
      srch_d.base  = stop_rgb(colors_01_q, colors_23_q, colors_45_q, 0);
    end
    // Outside the range: fixed colors
    if (tdiv_q[POS_BITS].status == STATUS_BELOW) begin
      srch_d.blend = 1'b0;
      srch_d.base  = COLOR_BELOW;
    end else if (tdiv_q[POS_BITS].status == STATUS_ABOVE) begin
      srch_d.blend = 1'b0;
      srch_d.base  = COLOR_ABOVE;
    end
  end

  // Weight both end colors per channel
  always_comb begin
    logic [POS_BITS-1:0] w_lo;
    w_lo          = srch_q.d - srch_q.n;
    prod_d.status = srch_q.status;
    prod_d.blend  = srch_q.blend;
    prod_d.base   = srch_q.base;
    prod_d.d      = srch_q.d;
    for (int c = 0; c < 3; c++) begin
      prod_d.pa[c] = BLEND_W'(srch_q.ca[CH_W*c +: CH_W]) * BLEND_W'(w_lo);
      prod_d.pb[c] = BLEND_W'(srch_q.cb[CH_W*c +: CH_W]) * BLEND_W'(srch_q.n);
    end
  end

  // Sum products and add half the span for rounding
  always_comb begin
    bdiv_d.status = prod_q.status;
    bdiv_d.blend  = prod_q.blend;
    bdiv_d.base   = prod_q.base;
    bdiv_d.d      = prod_q.d;
    bdiv_d.quo    = '0;
    for (int c = 0; c < 3; c++) begin
      bdiv_d.rem[c] = prod_q.pa[c] + prod_q.pb[c]
                    + {{(CH_W+1){1'b0}}, prod_q.d[POS_BITS-1:1]};
    end
  end

  // Choose blended or direct color
  always_comb begin
    out_d.status = bdiv_q[CH_W].status;
    out_d.rgb    = bdiv_q[CH_W].blend ? bdiv_q[CH_W].quo : bdiv_q[CH_W].base;
  end

  // --------------------------------------------------------------------------
  // Stage registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      rng_q     <= rng_d;
      tdiv_q[0] <= tdiv_d;
      for (int j = 0; j < POS_BITS; j++) begin
        tdiv_q[j+1] <= tdiv_step(tdiv_q[j], POS_BITS-1-j);
      end
      srch_q    <= srch_d;
      prod_q    <= prod_d;
      bdiv_q[0] <= bdiv_d;
      for (int j = 0; j < CH_W; j++) begin
        bdiv_q[j+1] <= bdiv_step(bdiv_q[j], CH_W-1-j);
      end
      out_q     <= out_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output channel
  // --------------------------------------------------------------------------
  assign color_o.valid        = vld_q[PIPE_DEPTH-1];
  assign color_o.red          = out_q.rgb[3*CH_W-1:2*CH_W];
  assign color_o.green        = out_q.rgb[2*CH_W-1:CH_W];
  assign color_o.blue         = out_q.rgb[CH_W-1:0];
  assign color_o.range_status = out_q.status;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A stalled output item holds the whole pipe
  a_stall_blocks_input: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    color_o.valid && !color_o.ready |-> !sample_i.ready
  ) else $error("input accepted while output item is stalled");

  // No status code outside the defined set
  a_status_code: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    color_o.valid |-> !(color_o.range_status[1] && color_o.range_status[0])
  ) else $error("undefined range status");

  // Below-range items carry the fixed light green
  a_below_color: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    color_o.valid && color_o.range_status == STATUS_BELOW
      |-> {color_o.red, color_o.green, color_o.blue} == COLOR_BELOW
  ) else $error("below-range item with wrong color");

  // Above-range items carry the fixed dark green
  a_above_color: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    color_o.valid && color_o.range_status == STATUS_ABOVE
      |-> {color_o.red, color_o.green, color_o.blue} == COLOR_ABOVE
  ) else $error("above-range item with wrong color");

endmodule
